>>> rtl/fcrb_pkg.sv
// shared types and codes for the frame commit receive ring buffer
// no dependencies
`timescale 1ns / 1ps

package fcrb_pkg;

	localparam logic [2:0] REQ_BYTE  = 3'd0;
	localparam logic [2:0] REQ_IDLE  = 3'd1;
	localparam logic [2:0] REQ_READ  = 3'd2;
	localparam logic [2:0] REQ_FLUSH = 3'd3;
	localparam logic [2:0] REQ_ERROR = 3'd4;

	localparam int CNT_TOP = 16'hFFFF;

	typedef struct packed {
		logic clr_en;
		logic take;
		logic start_read;
		logic emit_rd;
		logic issue_next;
	} fcrb_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
		logic is_read;
		logic rd_empty;
		logic rd_more;
	} fcrb_stat_t;

endpackage

>>> rtl/frame_commit_rx_ring_buffer.sv
// top level of the frame commit receive ring buffer
// depends on fcrb_pkg, fcrb_ctrl and fcrb_datapath
`timescale 1ns / 1ps

// Request channel (req_valid/req_ready) carries one request per transfer:
// a received byte, an idle-line commit, a read, a flush or a line error.
// Result channel (res_valid/res_ready) returns one transfer per non-read
// request, and one transfer per byte for a read, the final one with last set.
// A read that has nothing to return gives a single status transfer.
// Non-read requests: the result is registered at the request transfer and
// shows in the next cycle; with the receiver ready, one request per cycle.
// Reads: the first byte passes the single registered read port of the byte
// store and then the result register, then one byte per cycle while the receiver is ready.
// The next request is taken in the cycle the last byte of a read leaves.
// available_count and the error totals follow the state after the request.
// After reset the store is cleared one entry per cycle, all BUF_DEPTH entries,
// with req_ready low. A stalled receiver holds the result register and
// stops the read burst; no request is taken until the result is taken.

module frame_commit_rx_ring_buffer #(
	parameter int BUF_DEPTH = 256,
	parameter int MAX_READ  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  req_type,
	input  logic [7:0]  rx_byte,
	input  logic [6:0]  max_len,
	input  logic        overrun_err,
	input  logic        framing_err,
	input  logic        noise_err,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [7:0]  data_byte,
	output logic        data_valid,
	output logic        last,
	output logic [7:0]  available_count,
	output logic [7:0]  frame_length,
	output logic        overflow_dropped,
	output logic [15:0] overrun_total,
	output logic [15:0] framing_total,
	output logic [15:0] noise_total
);
	import fcrb_pkg::*;

	fcrb_cmd_t  cmd;
	fcrb_stat_t stat;

	fcrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	fcrb_datapath #(
		.BUF_DEPTH (BUF_DEPTH),
		.MAX_READ  (MAX_READ)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_type         (req_type),
		.rx_byte          (rx_byte),
		.max_len          (max_len),
		.overrun_err      (overrun_err),
		.framing_err      (framing_err),
		.noise_err        (noise_err),
		.cmd              (cmd),
		.stat             (stat),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.data_byte        (data_byte),
		.data_valid       (data_valid),
		.last             (last),
		.available_count  (available_count),
		.frame_length     (frame_length),
		.overflow_dropped (overflow_dropped),
		.overrun_total    (overrun_total),
		.framing_total    (framing_total),
		.noise_total      (noise_total)
	);

endmodule

>>> rtl/fcrb_ctrl.sv
// controller state machine: clearing pass, request intake, read burst
// depends on fcrb_pkg
`timescale 1ns / 1ps

module fcrb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  fcrb_pkg::fcrb_stat_t stat,
	output fcrb_pkg::fcrb_cmd_t  cmd
);
	import fcrb_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd            = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = stat.out_free;
				if (req_valid && stat.out_free) begin
					cmd.take = 1'b1;
					if (stat.is_read && !stat.rd_empty) begin
						cmd.start_read = 1'b1;
						state_d        = ST_READ;
					end
				end
			end
			ST_READ: begin
				if (stat.out_free) begin
					cmd.emit_rd = 1'b1;
					if (stat.rd_more) begin
						cmd.issue_next = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/fcrb_datapath.sv
// datapath: byte store, ring pointers, error counters and result register
// depends on fcrb_pkg
`timescale 1ns / 1ps

module fcrb_datapath #(
	parameter int BUF_DEPTH = 256,
	parameter int MAX_READ  = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           req_type,
	input  logic [7:0]           rx_byte,
	input  logic [6:0]           max_len,
	input  logic                 overrun_err,
	input  logic                 framing_err,
	input  logic                 noise_err,
	input  fcrb_pkg::fcrb_cmd_t  cmd,
	output fcrb_pkg::fcrb_stat_t stat,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [7:0]           data_byte,
	output logic                 data_valid,
	output logic                 last,
	output logic [7:0]           available_count,
	output logic [7:0]           frame_length,
	output logic                 overflow_dropped,
	output logic [15:0]          overrun_total,
	output logic [15:0]          framing_total,
	output logic [15:0]          noise_total
);
	import fcrb_pkg::*;

	localparam int PTR_W = $clog2(BUF_DEPTH);
	localparam int CNT_W = $clog2(MAX_READ + 1);
	localparam int CW    = (PTR_W > 7) ? PTR_W : 7;
	localparam logic [PTR_W:0]   DEPTH_W = (PTR_W + 1)'(BUF_DEPTH);
	localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(BUF_DEPTH - 1);
	localparam logic [6:0]       MAX_W   = 7'(MAX_READ);

	function automatic logic [PTR_W-1:0] ring_dist(input logic [PTR_W-1:0] to,
	                                               input logic [PTR_W-1:0] from);
		logic [PTR_W:0] t;
		t = {1'b0, to} - {1'b0, from};
		if (to < from) begin
			t = t + DEPTH_W;
		end
		return t[PTR_W-1:0];
	endfunction

	function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
		return (p == LAST_P) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] c);
		return (c == 16'(CNT_TOP)) ? c : c + 16'd1;
	endfunction

	logic [7:0]       mem [BUF_DEPTH];
	logic [7:0]       rd_data_q;
	logic [PTR_W-1:0] wr_q, head_q, tail_q, cur_q, clr_idx_q;
	logic [CNT_W-1:0] rem_q;
	logic [15:0]      ovr_q, frm_q, nse_q;
	logic             out_valid_q;
	logic [7:0]       data_q, frame_q;
	logic             dvalid_q, last_q, dropped_q;

	logic [PTR_W-1:0] avail, frame, free_sp, tail_rd;
	logic [PTR_W:0]   tail_sum;
	logic [6:0]       want;
	logic [CW-1:0]    n_x;
	logic [CNT_W-1:0] n;
	logic             dropped;
	logic             we, re;
	logic [PTR_W-1:0] waddr, raddr;
	logic [7:0]       wdata;
	logic             load_st;

	assign avail   = ring_dist(head_q, tail_q);
	assign want    = (max_len > MAX_W) ? MAX_W : max_len;
	assign n_x     = (CW'(avail) < CW'(want)) ? CW'(avail) : CW'(want);
	assign n       = n_x[CNT_W-1:0];
	assign tail_sum = {1'b0, tail_q} + (PTR_W + 1)'(n);
	assign tail_rd = (tail_sum >= DEPTH_W) ? PTR_W'(tail_sum - DEPTH_W) : tail_sum[PTR_W-1:0];
	assign frame   = ring_dist(wr_q, head_q);
	assign free_sp = (tail_q == head_q) ? LAST_P : ring_dist(tail_q, head_q) - 1'b1;
	assign dropped = frame > free_sp;

	assign stat.clr_last = (clr_idx_q == LAST_P);
	assign stat.out_free = !out_valid_q || res_ready;
	assign stat.is_read  = (req_type == REQ_READ);
	assign stat.rd_empty = (n_x == '0);
	assign stat.rd_more  = (rem_q > CNT_W'(1));

	// store ports
	assign we    = cmd.clr_en || (cmd.take && req_type == REQ_BYTE);
	assign waddr = cmd.clr_en ? clr_idx_q : wr_q;
	assign wdata = cmd.clr_en ? 8'd0 : rx_byte;
	assign re    = cmd.start_read || cmd.issue_next;
	assign raddr = cmd.start_read ? tail_q : cur_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			wr_q      <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			cur_q     <= '0;
			rem_q     <= '0;
			ovr_q     <= '0;
			frm_q     <= '0;
			nse_q     <= '0;
		end else begin
			if (cmd.clr_en) begin
				clr_idx_q <= inc(clr_idx_q);
			end
			if (cmd.take) begin
				case (req_type)
					REQ_BYTE: begin
						wr_q <= inc(wr_q);
					end
					REQ_IDLE: begin
						head_q <= wr_q;
						if (dropped) begin
							tail_q <= wr_q;
						end
					end
					REQ_READ: begin
						if (cmd.start_read) begin
							tail_q <= tail_rd;
							rem_q  <= n;
							cur_q  <= inc(tail_q);
						end
					end
					REQ_FLUSH: begin
						tail_q <= head_q;
					end
					REQ_ERROR: begin
						if (overrun_err) ovr_q <= sat_inc(ovr_q);
						if (framing_err) frm_q <= sat_inc(frm_q);
						if (noise_err)   nse_q <= sat_inc(nse_q);
						wr_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.emit_rd) begin
				rem_q <= rem_q - 1'b1;
			end
			if (cmd.issue_next) begin
				cur_q <= inc(cur_q);
			end
		end
	end

	// result register
	assign load_st = cmd.take && !cmd.start_read;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_st || cmd.emit_rd) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_rd) begin
			data_q    <= rd_data_q;
			dvalid_q  <= 1'b1;
			last_q    <= !stat.rd_more;
			frame_q   <= 8'd0;
			dropped_q <= 1'b0;
		end else if (load_st) begin
			data_q    <= 8'd0;
			dvalid_q  <= 1'b0;
			last_q    <= 1'b1;
			frame_q   <= (req_type == REQ_IDLE) ? 8'(frame) : 8'd0;
			dropped_q <= (req_type == REQ_IDLE) && dropped;
		end
	end

	assign res_valid        = out_valid_q;
	assign data_byte        = data_q;
	assign data_valid       = dvalid_q;
	assign last             = last_q;
	assign frame_length     = frame_q;
	assign overflow_dropped = dropped_q;
	assign available_count  = 8'(avail);
	assign overrun_total    = ovr_q;
	assign framing_total    = frm_q;
	assign noise_total      = nse_q;

endmodule
